// ===== hw/rtl/address_range_reservation_table_core_assert.svh =====
// Assertion macros for the address range reservation table core
`ifndef ADDRESS_RANGE_RESERVATION_TABLE_CORE_ASSERT_SVH
`define ADDRESS_RANGE_RESERVATION_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define ARART_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arart: same-cycle property failed");

// Next-cycle implication, disabled while reset is held
`define ARART_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arart: next-cycle property failed");

`endif

// ===== hw/rtl/arart_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes of the address range reservation table
package arart_pkg;

    localparam int MAX_RANGES  = 16;
    localparam int ALIGN_LOG2  = 6;
    localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;
    localparam int IDX_W       = $clog2(MAX_RANGES);
    localparam int CNT_W       = $clog2(MAX_RANGES + 1);
    localparam int ADDR_W      = 64;
    localparam int PERM_W      = 3;

    localparam logic [ADDR_W-1:0] ALIGN_MASK = ADDR_W'(ALIGN_BYTES - 1);

    typedef enum logic [1:0] {
        MODE_ALLOC     = 2'd0,
        MODE_RESERVE   = 2'd1,
        MODE_UNRESERVE = 2'd2,
        MODE_CHECK     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOGAP    = 3'd2,
        ST_OVERLAP  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  length;
        logic [PERM_W-1:0]  perm_bits;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  result_address;
        logic               granted;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
        logic [PERM_W-1:0]  perm;
    } t_entry;

    typedef struct packed {
        logic carry;
        logic zero;
    } t_alu_flags;

endpackage

// ===== hw/rtl/address_range_reservation_table_core.sv =====
`timescale 1ns / 1ps
// Top level: sorted range table, first-fit allocator and permission check
//
// Usage:
//   Drive i_req and raise start while busy is low; the request is taken at
//   that clock edge and busy stays high until the operation completes.
//   The result appears on o_rsp for exactly one cycle with o_done high;
//   the receiver cannot hold it off. busy is low in that cycle, so the next
//   request may be taken at the same edge that ends the result cycle.
//   Steps, K = entries moved:
//     check      : scan the entries, then a length and an offset test
//     unreserve  : scan the entries, then move the K entries above down
//     reserve    : scan, overlap tests with both neighbours, K moves, insert
//     allocate   : each entry is tested for a gap, then a reserve pass
//   One shared 64-bit adder does every address compare; entry moves use
//   the single table write port at one entry a cycle.
//   Reset empties the table at once; stale entries are never read.
module address_range_reservation_table_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  arart_pkg::t_req  i_req,
    output logic             o_done,
    output arart_pkg::t_rsp  o_rsp
);

`include "address_range_reservation_table_core_assert.svh"

    localparam int IDX_W  = arart_pkg::IDX_W;
    localparam int CNT_W  = arart_pkg::CNT_W;
    localparam int ADDR_W = arart_pkg::ADDR_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_R_SCAN,
        S_R_NEXT,
        S_R_PREV,
        S_R_PREV2,
        S_R_PLACE,
        S_SHIFT_UP,
        S_INSERT,
        S_A_END1,
        S_A_END2,
        S_A_GAP1,
        S_A_GAP2,
        S_A_TAIL,
        S_U_SCAN,
        S_U_SHIFT,
        S_C_SCAN,
        S_C_LEN,
        S_C_OFF
    } t_state;

    function automatic arart_pkg::t_rsp f_rsp(input arart_pkg::t_status st,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic grant);
        arart_pkg::t_rsp rsp;
        rsp.status         = st;
        rsp.result_address = addr;
        rsp.granted        = grant;
        return rsp;
    endfunction

    arart_pkg::t_entry r_mem [arart_pkg::MAX_RANGES];

    t_state            r_state, n_state;
    arart_pkg::t_req   r_req, n_req;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_pos, n_pos;
    arart_pkg::t_entry r_rd;
    arart_pkg::t_entry r_prev, n_prev;
    logic [ADDR_W-1:0] r_tmp, n_tmp;
    logic              r_cy, n_cy;
    logic [ADDR_W-1:0] r_end, n_end;
    logic              r_end_ok, n_end_ok;
    logic [ADDR_W-1:0] r_off, n_off;
    logic              r_found, n_found;
    arart_pkg::t_rsp   r_rsp, n_rsp;
    logic              r_done, n_done;

    logic              w_we;
    logic [IDX_W-1:0]  w_wa;
    arart_pkg::t_entry w_wd;

    logic [ADDR_W-1:0]     w_alu_a, w_alu_b, w_sum;
    logic                  w_alu_sub;
    arart_pkg::t_alu_flags w_flags;

    logic w_last, w_full;

    assign w_last = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign w_full = (r_count == CNT_W'(arart_pkg::MAX_RANGES));

    arart_alu u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_sub   (w_alu_sub),
        .o_sum   (w_sum),
        .o_flags (w_flags)
    );

    always_comb begin
        w_alu_a   = r_tmp;
        w_alu_b   = r_req.length;
        w_alu_sub = 1'b1;
        case (r_state)
            S_R_SCAN, S_U_SCAN: begin
                w_alu_a = r_rd.base;
                w_alu_b = r_req.address;
            end
            S_R_NEXT, S_A_GAP2: begin
                w_alu_a = r_tmp;
                w_alu_b = r_req.length;
            end
            S_R_PREV: begin
                w_alu_a = r_req.address;
                w_alu_b = r_prev.base;
            end
            S_R_PREV2: begin
                w_alu_a = r_tmp;
                w_alu_b = r_prev.length;
            end
            S_A_END1: begin
                w_alu_a   = r_rd.base;
                w_alu_b   = r_rd.length;
                w_alu_sub = 1'b0;
            end
            S_A_END2: begin
                w_alu_a   = r_tmp;
                w_alu_b   = arart_pkg::ALIGN_MASK;
                w_alu_sub = 1'b0;
            end
            S_A_GAP1: begin
                w_alu_a = r_rd.base & ~arart_pkg::ALIGN_MASK;
                w_alu_b = r_end;
            end
            S_A_TAIL: begin
                w_alu_a   = r_end;
                w_alu_b   = r_req.length;
                w_alu_sub = 1'b0;
            end
            S_C_SCAN: begin
                w_alu_a = r_req.address;
                w_alu_b = r_rd.base;
            end
            S_C_LEN: begin
                w_alu_a = r_prev.length;
                w_alu_b = r_req.length;
            end
            S_C_OFF: begin
                w_alu_a = r_tmp;
                w_alu_b = r_off;
            end
            default: begin
                w_alu_a   = r_tmp;
                w_alu_b   = r_req.length;
                w_alu_sub = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_prev   = r_prev;
        n_tmp    = r_tmp;
        n_cy     = r_cy;
        n_end    = r_end;
        n_end_ok = r_end_ok;
        n_off    = r_off;
        n_found  = r_found;
        n_rsp    = r_rsp;
        n_done   = 1'b0;
        w_we     = 1'b0;
        w_wa     = r_idx;
        w_wd     = r_rd;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (start) begin
                    n_req   = i_req;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_idx   = '0;
                n_pos   = '0;
                n_found = 1'b0;
                case (r_req.mode)
                    arart_pkg::MODE_ALLOC: begin
                        if (r_req.length == '0) begin
                            n_rsp   = f_rsp(arart_pkg::ST_ZERO, '0, 1'b0);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else if (w_full) begin
                            n_rsp   = f_rsp(arart_pkg::ST_FULL, '0, 1'b0);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_count == '0) begin
                            n_req.address = '0;
                            n_state       = S_R_PREV;
                        end else begin
                            n_state = S_A_END1;
                        end
                    end
                    arart_pkg::MODE_RESERVE: begin
                        if (r_req.length == '0) begin
                            n_rsp   = f_rsp(arart_pkg::ST_ZERO, '0, 1'b0);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_count == '0) begin
                            n_state = S_R_PREV;
                        end else begin
                            n_state = S_R_SCAN;
                        end
                    end
                    arart_pkg::MODE_UNRESERVE: begin
                        if (r_count == '0) begin
                            n_rsp   = f_rsp(arart_pkg::ST_NOTFOUND, '0, 1'b0);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_U_SCAN;
                        end
                    end
                    arart_pkg::MODE_CHECK: begin
                        if (r_count == '0) begin
                            n_rsp   = f_rsp(arart_pkg::ST_OK, '0, 1'b0);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_C_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_R_SCAN: begin
                if (!w_flags.carry) begin
                    n_prev = r_rd;
                    if (w_last) begin
                        n_pos   = r_count;
                        n_state = S_R_PREV;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_pos = CNT_W'(r_idx);
                    if (w_flags.zero) begin
                        n_rsp   = f_rsp(arart_pkg::ST_OVERLAP, '0, 1'b0);
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_tmp   = w_sum;
                        n_state = S_R_NEXT;
                    end
                end
            end
            S_R_NEXT: begin
                if (!w_flags.carry) begin
                    n_rsp   = f_rsp(arart_pkg::ST_OVERLAP, '0, 1'b0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_R_PREV;
                end
            end
            S_R_PREV: begin
                if (r_pos == '0) begin
                    n_state = S_R_PLACE;
                end else begin
                    n_tmp   = w_sum;
                    n_state = S_R_PREV2;
                end
            end
            S_R_PREV2: begin
                if (!w_flags.carry) begin
                    n_rsp   = f_rsp(arart_pkg::ST_OVERLAP, '0, 1'b0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_R_PLACE;
                end
            end
            S_R_PLACE: begin
                if (w_full) begin
                    n_rsp   = f_rsp(arart_pkg::ST_FULL, '0, 1'b0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_pos == r_count) begin
                    n_state = S_INSERT;
                end else begin
                    n_idx   = IDX_W'(r_count - CNT_W'(1));
                    n_state = S_SHIFT_UP;
                end
            end
            S_SHIFT_UP: begin
                w_we = 1'b1;
                w_wa = r_idx + IDX_W'(1);
                w_wd = r_rd;
                if (CNT_W'(r_idx) == r_pos) begin
                    n_state = S_INSERT;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            S_INSERT: begin
                w_we         = 1'b1;
                w_wa         = IDX_W'(r_pos);
                w_wd.base    = r_req.address;
                w_wd.length  = r_req.length;
                w_wd.perm    = r_req.perm_bits;
                n_count      = r_count + CNT_W'(1);
                n_rsp        = f_rsp(arart_pkg::ST_OK,
                                     (r_req.mode == arart_pkg::MODE_ALLOC) ?
                                     r_req.address : '0, 1'b0);
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_A_END1: begin
                n_tmp   = w_sum;
                n_cy    = w_flags.carry;
                n_state = S_A_END2;
            end
            S_A_END2: begin
                n_end    = w_sum & ~arart_pkg::ALIGN_MASK;
                n_end_ok = !r_cy && !w_flags.carry;
                if (w_last) begin
                    n_state = S_A_TAIL;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_A_GAP1;
                end
            end
            S_A_GAP1: begin
                if (!r_end_ok || !w_flags.carry) begin
                    n_state = S_A_END1;
                end else begin
                    n_tmp   = w_sum;
                    n_state = S_A_GAP2;
                end
            end
            S_A_GAP2: begin
                if (w_flags.carry) begin
                    n_req.address = r_end;
                    n_idx         = '0;
                    n_state       = S_R_SCAN;
                end else begin
                    n_state = S_A_END1;
                end
            end
            S_A_TAIL: begin
                if (r_end_ok && (!w_flags.carry || w_flags.zero)) begin
                    n_req.address = r_end;
                    n_idx         = '0;
                    n_state       = S_R_SCAN;
                end else begin
                    n_rsp   = f_rsp(arart_pkg::ST_NOGAP, '0, 1'b0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_U_SCAN: begin
                if (w_flags.zero) begin
                    if (w_last) begin
                        n_count = r_count - CNT_W'(1);
                        n_rsp   = f_rsp(arart_pkg::ST_OK, '0, 1'b0);
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_U_SHIFT;
                    end
                end else if (w_last) begin
                    n_rsp   = f_rsp(arart_pkg::ST_NOTFOUND, '0, 1'b0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_U_SHIFT: begin
                w_we = 1'b1;
                w_wa = r_idx - IDX_W'(1);
                w_wd = r_rd;
                if (w_last) begin
                    n_count = r_count - CNT_W'(1);
                    n_rsp   = f_rsp(arart_pkg::ST_OK, '0, 1'b0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_C_SCAN: begin
                if (w_flags.carry) begin
                    n_prev  = r_rd;
                    n_found = 1'b1;
                    n_off   = w_sum;
                    if (w_last) begin
                        n_state = S_C_LEN;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_state = S_C_LEN;
                end
            end
            S_C_LEN: begin
                if (!r_found || !w_flags.carry) begin
                    n_rsp   = f_rsp(arart_pkg::ST_OK, '0, 1'b0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_tmp   = w_sum;
                    n_state = S_C_OFF;
                end
            end
            S_C_OFF: begin
                n_rsp   = f_rsp(arart_pkg::ST_OK, '0,
                                w_flags.carry &&
                                ((r_prev.perm & r_req.perm_bits) == r_req.perm_bits));
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_rsp   <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_prev   <= n_prev;
        r_tmp    <= n_tmp;
        r_cy     <= n_cy;
        r_end    <= n_end;
        r_end_ok <= n_end_ok;
        r_off    <= n_off;
        r_found  <= n_found;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[n_idx];
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `ARART_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    `ARART_ASSERT_NOW(a_done_when_idle, o_done, !busy)
    `ARART_ASSERT_NOW(a_count_moves_on_done, $past(i_rst_n) && (r_count != $past(r_count)), o_done)
    `ARART_ASSERT_NOW(a_grant_only_ok, o_done && o_rsp.granted, (o_rsp.status == arart_pkg::ST_OK) && (o_rsp.result_address == '0))

endmodule

// ===== hw/rtl/arart_alu.sv =====
`timescale 1ns / 1ps
// Shared 64-bit add/subtract unit with carry and zero flags
module arart_alu (
    input  logic [arart_pkg::ADDR_W-1:0] i_a,
    input  logic [arart_pkg::ADDR_W-1:0] i_b,
    input  logic                         i_sub,
    output logic [arart_pkg::ADDR_W-1:0] o_sum,
    output arart_pkg::t_alu_flags        o_flags
);

    logic [arart_pkg::ADDR_W-1:0] w_b;
    logic [arart_pkg::ADDR_W:0]   w_full;

    assign w_b    = i_sub ? ~i_b : i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + (arart_pkg::ADDR_W + 1)'(i_sub);

    assign o_sum         = w_full[arart_pkg::ADDR_W-1:0];
    assign o_flags.carry = w_full[arart_pkg::ADDR_W];
    assign o_flags.zero  = (w_full[arart_pkg::ADDR_W-1:0] == '0);

endmodule
